// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by sqa_tsu_check.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sqa_tsu_pkg.sv -----
// ---------------------------------------------------------------------------
// SQA spin update package
// Types, codes and helpers shared by the trotter spin update block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sqa_tsu_pkg;

   localparam int ACC_W = 48;   // energy accumulator
   localparam int DE_W  = 52;   // decision arithmetic, never overflows

   typedef enum logic [1:0] {
      REQ_WRITE    = 2'd0,
      REQ_READ     = 2'd1,
      REQ_COUPLING = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_TROTTER_COUNT  = 2'd0,
      CSR_QUANTUM_ENERGY = 2'd1,
      CSR_HALF_INV_BETA  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [3:0]         trotter_count;
      logic signed [31:0] quantum_energy;
      logic [30:0]        half_inv_beta;
   } cfg_type;

   // item held in the work stage, indexes already reduced
   typedef struct packed {
      req_kind_type       req_kind;
      logic [2:0]         trotter;
      logic [9:0]         spin;
      logic [9:0]         partner;
      logic signed [31:0] coupling;
      logic               write_spin;
      logic signed [31:0] field_h;
      logic               last_term;
   } item_type;

   typedef struct packed {
      logic       en;
      logic [2:0] trotter;
      logic [9:0] spin;
      logic       value;
   } wr_type;

   typedef struct packed {
      logic [2:0] trotter;
      logic [9:0] spin;
      logic       value;
      logic       flipped;
   } result_type;

   // remainder by restoring compare/subtract steps; quotient stays below 128
   function automatic logic [9:0] mod_reduce(input logic [9:0]  value,
                                             input logic [12:0] modulus);
      logic [19:0] rem;
      logic [19:0] step;
      rem = 20'(value);
      for (int k = 6; k >= 0; k--) begin
         step = 20'(modulus) << k;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[9:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/sqa_tsu_if.sv -----
// ---------------------------------------------------------------------------
// SQA spin update channels
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sqa_tsu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [2:0]         trotter;
   logic [9:0]         spin_index;
   logic [9:0]         partner_index;
   logic signed [31:0] coupling;
   logic               write_spin;
   logic signed [31:0] field_h;
   logic signed [31:0] log_random;
   logic               last_term;

   modport source (output valid, req_type, trotter, spin_index, partner_index,
                   coupling, write_spin, field_h, log_random, last_term,
                   input ready);
   modport sink (input valid, req_type, trotter, spin_index, partner_index,
                 coupling, write_spin, field_h, log_random, last_term,
                 output ready);
endinterface

interface sqa_tsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_trotter;
   logic [9:0] out_spin_index;
   logic       spin_value;
   logic       flipped;

   modport source (output valid, out_trotter, out_spin_index, spin_value, flipped,
                   input ready);
   modport sink (input valid, out_trotter, out_spin_index, spin_value, flipped,
                 output ready);
endinterface

interface sqa_tsu_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/sqa_tsu_csr.sv -----
// ---------------------------------------------------------------------------
// SQA spin update registers
// Slice count, quantum coupling energy and 0.5/beta.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqa_tsu_csr (
   input  logic                 clock,
   input  logic                 reset,
   sqa_tsu_csr_if.sink          csr_bus,
   output sqa_tsu_pkg::cfg_type cfg
);
   import sqa_tsu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_TROTTER_COUNT:  cfg_in.trotter_count  = csr_bus.data[3:0];
            CSR_QUANTUM_ENERGY: cfg_in.quantum_energy = csr_bus.data;
            CSR_HALF_INV_BETA:  cfg_in.half_inv_beta  = csr_bus.data[30:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trotter_count  <= 4'd8;
         cfg_ff.quantum_energy <= '0;
         cfg_ff.half_inv_beta  <= 31'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/sqa_tsu_spin_bank.sv -----
// ---------------------------------------------------------------------------
// SQA spin bank
// One trotter slice of spin bits: one write port, two registered read ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqa_tsu_spin_bank #(
   parameter int SPIN_COUNT = 1024
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(SPIN_COUNT)-1:0] wr_addr,
   input  logic                          wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(SPIN_COUNT)-1:0] rd_addr_i,
   input  logic [$clog2(SPIN_COUNT)-1:0] rd_addr_j,
   output logic                          rd_data_i,
   output logic                          rd_data_j
);

   logic spin_ff [SPIN_COUNT];
   logic rd_i_ff;
   logic rd_j_ff;

   // read-first: a write at the same edge is picked up by forwarding upstream
   always_ff @(posedge clock) begin
      if (wr_en) begin
         spin_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_i_ff <= spin_ff[rd_addr_i];
         rd_j_ff <= spin_ff[rd_addr_j];
      end
   end

   assign rd_data_i = rd_i_ff;
   assign rd_data_j = rd_j_ff;

endmodule

`default_nettype wire

// ----- hdl/sqa_tsu_update.sv -----
// ---------------------------------------------------------------------------
// SQA spin update datapath
// Coupling accumulate, neighbor term, Metropolis compare and write-back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqa_tsu_update #(
   parameter int TROTTER_SLICES = 8
) (
   input  sqa_tsu_pkg::item_type                item,
   input  sqa_tsu_pkg::cfg_type                 cfg,
   input  logic signed [63:0]                   product,
   input  logic signed [sqa_tsu_pkg::ACC_W-1:0] acc,
   input  logic [TROTTER_SLICES-1:0]            rd_i,
   input  logic [TROTTER_SLICES-1:0]            rd_j,
   input  sqa_tsu_pkg::wr_type                  last_wr,
   output logic signed [sqa_tsu_pkg::ACC_W-1:0] acc_next,
   output sqa_tsu_pkg::wr_type                  wr,
   output sqa_tsu_pkg::result_type              result,
   output logic                                 has_result
);
   import sqa_tsu_pkg::*;

   localparam int TW = $clog2(TROTTER_SLICES);
   localparam int NW = TW + 1;

   logic [TW-1:0]            slice;
   logic [TW-1:0]            up;
   logic [TW-1:0]            down;
   logic [NW-1:0]            n;
   logic                     s_j;
   logic                     s_me;
   logic                     s_up;
   logic                     s_down;
   logic                     flip;
   logic                     is_decide;
   logic signed [ACC_W-1:0]  cpl;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [DE_W-1:0]   q;
   logic signed [DE_W-1:0]   qsel;
   logic signed [DE_W-1:0]   de_sum;
   logic signed [DE_W-1:0]   de_full;
   logic signed [DE_W-1:0]   de;
   logic signed [DE_W-1:0]   thr;

   // newest spin: the write retired at the edge this item was read
   function automatic logic fwd(input logic [TW-1:0] bank, input logic [9:0] spin,
                                input logic raw, input wr_type w);
      return (w.en && TW'(w.trotter) == bank && w.spin == spin) ? w.value : raw;
   endfunction

   always_comb begin
      slice = TW'(item.trotter);

      if (cfg.trotter_count == 4'd0) begin
         n = NW'(1);
      end else if ({4'd0, cfg.trotter_count} > 8'(TROTTER_SLICES)) begin
         n = NW'(TROTTER_SLICES);
      end else begin
         n = NW'(cfg.trotter_count);
      end

      up   = (slice == '0) ? TW'(n - NW'(1)) : slice - TW'(1);
      down = ((NW'(slice) + NW'(1)) >= n) ? '0 : slice + TW'(1);

      s_j    = fwd(slice, item.partner, rd_j[slice], last_wr);
      s_me   = fwd(slice, item.spin,    rd_i[slice], last_wr);
      s_up   = fwd(up,    item.spin,    rd_i[up],    last_wr);
      s_down = fwd(down,  item.spin,    rd_i[down],  last_wr);

      cpl     = {{(ACC_W-32){item.coupling[31]}}, item.coupling};
      term    = s_j ? cpl : -cpl;
      acc_sum = acc + term;

      q = {{(DE_W-32){cfg.quantum_energy[31]}}, cfg.quantum_energy};
      if (s_up == s_down) begin
         qsel = s_up ? -q : q;
      end else begin
         qsel = '0;
      end

      de_sum  = {{(DE_W-ACC_W){acc_sum[ACC_W-1]}}, acc_sum} + qsel;
      de_full = {de_sum[DE_W-2:0], 1'b0}
              + {{(DE_W-32){item.field_h[31]}}, item.field_h};
      de      = s_me ? de_full : -de_full;

      // floor of the Q16.16 product is its arithmetic shift
      thr  = {{(DE_W-48){product[63]}}, product[63:16]};
      flip = de > thr;

      is_decide  = (item.req_kind == REQ_COUPLING) && item.last_term;
      has_result = (item.req_kind == REQ_READ) || is_decide;

      if (item.req_kind == REQ_COUPLING) begin
         acc_next = item.last_term ? '0 : acc_sum;
      end else begin
         acc_next = acc;
      end

      wr.en      = (item.req_kind == REQ_WRITE) || is_decide;
      wr.trotter = item.trotter;
      wr.spin    = item.spin;
      wr.value   = (item.req_kind == REQ_WRITE) ? item.write_spin : (s_me ^ flip);

      result.trotter = item.trotter;
      result.spin    = item.spin;
      result.value   = (item.req_kind == REQ_READ) ? s_me : (s_me ^ flip);
      result.flipped = (item.req_kind == REQ_READ) ? 1'b0 : flip;
   end

endmodule

`default_nettype wire

// ----- hdl/sqa_trotter_spin_update.sv -----
// ---------------------------------------------------------------------------
// SQA trotter spin update
// Spin store per trotter slice with Metropolis flip decision on coupling sums.
// ---------------------------------------------------------------------------
//  channel   dir   handshake      carries
//  req_bus   in    valid/ready    write, read or coupling term
//  rsp_bus   out   valid/ready    spin read back or update outcome
//  csr_bus   in    valid/ready    register index and write data
//
//  One item per cycle while req ready stays high.
//  Spin banks are read at accept, the work stage adds and decides, the
//  result register holds the outcome; writes retire at the work stage exit.
//  req ready drops only while the result register is full and not taken
//  and the work stage holds an item that yields a result.
//  Reset clears valids and accumulator, presets registers; spin bits stay.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqa_trotter_spin_update #(
   parameter int TROTTER_SLICES = 8,
   parameter int SPIN_COUNT     = 1024
) (
   input  logic           clock,
   input  logic           reset,
   sqa_tsu_req_if.sink    req_bus,
   sqa_tsu_rsp_if.source  rsp_bus,
   sqa_tsu_csr_if.sink    csr_bus
);
   import sqa_tsu_pkg::*;

   localparam int AW = $clog2(SPIN_COUNT);
   localparam int TW = $clog2(TROTTER_SLICES);

   cfg_type                 cfg;
   logic                    accept;
   logic [2:0]              req_m;
   logic [9:0]              req_i;
   logic [9:0]              req_j;
   item_type                s1_ff;
   item_type                s1_in;
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic                    s1_adv;
   logic signed [63:0]      prod_ff;
   logic signed [63:0]      prod_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] acc_next;
   wr_type                  lw_ff;
   wr_type                  lw_in;
   wr_type                  wr_u;
   result_type              result_u;
   result_type              rsp_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    has_result;
   logic                    load_rsp;
   logic [TROTTER_SLICES-1:0] rd_i;
   logic [TROTTER_SLICES-1:0] rd_j;
   logic [TROTTER_SLICES-1:0] bank_wr;

   sqa_tsu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !s1_valid_ff || s1_adv;

   always_comb begin
      req_m = 3'(mod_reduce(10'(req_bus.trotter), 13'(TROTTER_SLICES)));
      req_i = mod_reduce(req_bus.spin_index, 13'(SPIN_COUNT));
      req_j = mod_reduce(req_bus.partner_index, 13'(SPIN_COUNT));

      s1_in.req_kind   = req_kind_type'(req_bus.req_type);
      s1_in.trotter    = req_m;
      s1_in.spin       = req_i;
      s1_in.partner    = req_j;
      s1_in.coupling   = req_bus.coupling;
      s1_in.write_spin = req_bus.write_spin;
      s1_in.field_h    = req_bus.field_h;
      s1_in.last_term  = req_bus.last_term;

      // threshold product, registered before the compare
      prod_in = req_bus.log_random * $signed({1'b0, cfg.half_inv_beta});
   end

   for (genvar g = 0; g < TROTTER_SLICES; g++) begin : g_bank
      sqa_tsu_spin_bank #(
         .SPIN_COUNT (SPIN_COUNT)
      ) u_bank (
         .clock     (clock),
         .wr_en     (bank_wr[g]),
         .wr_addr   (AW'(wr_u.spin)),
         .wr_data   (wr_u.value),
         .rd_en     (accept),
         .rd_addr_i (AW'(req_i)),
         .rd_addr_j (AW'(req_j)),
         .rd_data_i (rd_i[g]),
         .rd_data_j (rd_j[g])
      );
   end

   sqa_tsu_update #(
      .TROTTER_SLICES (TROTTER_SLICES)
   ) u_update (
      .item       (s1_ff),
      .cfg        (cfg),
      .product    (prod_ff),
      .acc        (acc_ff),
      .rd_i       (rd_i),
      .rd_j       (rd_j),
      .last_wr    (lw_ff),
      .acc_next   (acc_next),
      .wr         (wr_u),
      .result     (result_u),
      .has_result (has_result)
   );

   always_comb begin
      s1_adv   = s1_valid_ff && (!has_result || !rsp_valid_ff || rsp_bus.ready);
      load_rsp = s1_adv && has_result;

      for (int b = 0; b < TROTTER_SLICES; b++) begin
         bank_wr[b] = s1_adv && wr_u.en && (TW'(wr_u.trotter) == TW'(b));
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      acc_in = s1_adv ? acc_next : acc_ff;
      lw_in  = s1_adv ? wr_u : lw_ff;

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         lw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         lw_ff        <= lw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff   <= s1_in;
         prod_ff <= prod_in;
      end
      if (load_rsp) begin
         rsp_ff <= result_u;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_trotter    = rsp_ff.trotter;
   assign rsp_bus.out_spin_index = rsp_ff.spin;
   assign rsp_bus.spin_value     = rsp_ff.value;
   assign rsp_bus.flipped        = rsp_ff.flipped;

endmodule

`default_nettype wire

// ----- hdl/sqa_tsu_check.sv -----
// ---------------------------------------------------------------------------
// SQA spin update checker
// Port-level properties of the spin update block, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sqa_tsu_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic       last_term,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_out_trotter,
   input logic [9:0] rsp_out_spin_index,
   input logic       rsp_spin_value,
   input logic       rsp_flipped
);
   import sqa_tsu_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_trotter) && $stable(rsp_out_spin_index) && $stable(rsp_spin_value) && $stable(rsp_flipped), "stalled result changed")
   `ASSERT_IMPLY(a_ready_backpressure, clock, reset, !req_ready, rsp_valid && !rsp_ready, "request stalled without output back-pressure")
   `ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && (req_type == REQ_READ || (req_type == REQ_COUPLING && last_term)), 2), "result without a read or last coupling item")
   `ASSERT_IMPLY(a_read_no_flip, clock, reset, $rose(rsp_valid) && $past(req_valid && req_ready && req_type == REQ_READ, 2), !rsp_flipped, "read result marked flipped")

endmodule

bind sqa_trotter_spin_update sqa_tsu_check u_check (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_type           (req_bus.req_type),
   .last_term          (req_bus.last_term),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_out_trotter    (rsp_bus.out_trotter),
   .rsp_out_spin_index (rsp_bus.out_spin_index),
   .rsp_spin_value     (rsp_bus.spin_value),
   .rsp_flipped        (rsp_bus.flipped)
);

`default_nettype wire

// ----- verif/sqa_tsu_flip_checker.sv -----
// ---------------------------------------------------------------------------
// SQA spin update checker
// Watches the request, response and register channels of the spin update
// block, keeps its own spin bank, accumulator and registers, works out the
// outcome of every accepted item and compares each response with the oldest
// outcome still owed. Mismatch count and owed outcomes go to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqa_tsu_flip_checker (
   input  logic   clock,
   input  logic   reset,
   sqa_tsu_req_if req_mon,
   sqa_tsu_rsp_if rsp_mon,
   sqa_tsu_csr_if csr_mon,
   output int     pending_results,
   output int     mismatch_count
);
   import sqa_tsu_pkg::*;

   localparam int TROTTER_SLICES = 8;
   localparam int SPIN_COUNT     = 1024;

   bit                 spin_bank [TROTTER_SLICES][SPIN_COUNT];
   logic [ACC_W-1:0]   energy_acc;
   logic [3:0]         slices_in_use;
   logic signed [31:0] quantum_e;
   logic [30:0]        half_beta;
   result_type         owed_outcomes [$];

   function automatic void absorb_item(input logic [1:0] kind, input logic [2:0] trot,
                                       input logic [9:0] spin, input logic [9:0] partner,
                                       input logic signed [31:0] cpl, input logic ws,
                                       input logic signed [31:0] h,
                                       input logic signed [31:0] lr, input logic last);
      int                 m;
      int                 i;
      int                 j;
      int                 n;
      int                 up_s;
      int                 down_s;
      logic signed [47:0] cpl_wide;
      longint             de;
      longint             q;
      longint             thr;
      bit                 me;
      bit                 flip;
      result_type         r;
      m = int'(trot) % TROTTER_SLICES;
      i = int'(spin) % SPIN_COUNT;
      j = int'(partner) % SPIN_COUNT;
      case (kind)
         REQ_WRITE: begin
            spin_bank[m][i] = ws;
         end
         REQ_READ: begin
            r = '{trotter: 3'(m), spin: 10'(i), value: spin_bank[m][i], flipped: 1'b0};
            owed_outcomes.push_back(r);
         end
         REQ_COUPLING: begin
            cpl_wide = 48'(cpl);
            energy_acc = energy_acc + (spin_bank[m][j] ? cpl_wide : -cpl_wide);
            if (last) begin
               n = int'(slices_in_use);
               if (n == 0) n = 1;
               if (n > TROTTER_SLICES) n = TROTTER_SLICES;
               up_s   = (m == 0) ? n - 1 : m - 1;
               down_s = (m + 1 >= n) ? 0 : m + 1;
               me = spin_bank[m][i];
               de = longint'($signed(energy_acc));
               q  = longint'(quantum_e);
               // quantum term only counts when both ring neighbors agree
               if (spin_bank[up_s][i] == spin_bank[down_s][i]) begin
                  de += spin_bank[up_s][i] ? -q : q;
               end
               de = de * 2 + longint'(h);
               if (!me) de = -de;
               thr  = (longint'(lr) * longint'(half_beta)) >>> 16;
               flip = de > thr;
               me   = me ^ flip;
               spin_bank[m][i] = me;
               energy_acc = '0;
               r = '{trotter: 3'(m), spin: 10'(i), value: me, flipped: flip};
               owed_outcomes.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      result_type seen;
      result_type want;
      if (reset) begin
         energy_acc    = '0;
         slices_in_use = 4'd8;
         quantum_e     = '0;
         half_beta     = 31'd65536;
         owed_outcomes.delete();
      end else begin
         // responses first: an item taken this edge cannot answer yet
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{trotter: rsp_mon.out_trotter, spin: rsp_mon.out_spin_index,
                     value: rsp_mon.spin_value, flipped: rsp_mon.flipped};
            if (owed_outcomes.size() == 0) begin
               mismatch_count++;
               $display("%t unexpected result: expected none, got %0d/%0d value %0d flip %0d",
                        $time, seen.trotter, seen.spin, seen.value, seen.flipped);
            end else begin
               want = owed_outcomes.pop_front();
               if (seen.trotter !== want.trotter || seen.spin !== want.spin ||
                   seen.value !== want.value || seen.flipped !== want.flipped) begin
                  mismatch_count++;
                  $display("%t mismatch: expected %0d/%0d value %0d flip %0d",
                           $time, want.trotter, want.spin, want.value, want.flipped);
                  $display("%t           got %0d/%0d value %0d flip %0d",
                           $time, seen.trotter, seen.spin, seen.value, seen.flipped);
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_TROTTER_COUNT:  slices_in_use = csr_mon.data[3:0];
               CSR_QUANTUM_ENERGY: quantum_e     = csr_mon.data;
               CSR_HALF_INV_BETA:  half_beta     = csr_mon.data[30:0];
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_item(req_mon.req_type, req_mon.trotter, req_mon.spin_index,
                        req_mon.partner_index, req_mon.coupling, req_mon.write_spin,
                        req_mon.field_h, req_mon.log_random, req_mon.last_term);
         end
      end
      pending_results = owed_outcomes.size();
   end

endmodule

`default_nettype wire

// ----- verif/tb_sqa_trotter_spin_update.sv -----
// ---------------------------------------------------------------------------
// SQA trotter spin update testbench
// Drives spin writes, reads and coupling runs into the block with random
// gaps and response stalls, sweeps the slice count, quantum energy and
// temperature registers through several settings, and leaves the checking
// to the flip checker. Gives the verdict once all outcomes have come back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_sqa_trotter_spin_update;
   import sqa_tsu_pkg::*;

   localparam logic [1:0] REQ_IGNORED = 2'd3;
   localparam int         SPIN_TOTAL  = 1024;
   localparam int         PHASE_ITEMS = 265;

   typedef struct {
      logic [1:0]         kind;
      logic [2:0]         slice_idx;
      logic [9:0]         spin;
      logic [9:0]         partner;
      logic signed [31:0] coupling;
      logic               up_value;
      logic signed [31:0] field;
      logic signed [31:0] ln_draw;
      logic               last;
   } spin_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   pending_results;
   int   mismatch_count;

   bit   spin_loaded [8][SPIN_TOTAL];
   int   loaded_addrs [$];
   int   items_sent;
   bit   sender_gaps;
   bit   squeeze_pending;

   sqa_tsu_req_if req_ch ();
   sqa_tsu_rsp_if rsp_ch ();
   sqa_tsu_csr_if csr_ch ();

   sqa_trotter_spin_update dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   sqa_tsu_flip_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_mon         (csr_ch),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   always #10 clock = ~clock;

   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (!sender_gaps || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [31:0] rand_q16();
      case ($urandom_range(0, 9))
         0:          return 32'h7fff_ffff;
         1:          return 32'h8000_0000;
         2, 3, 4, 5: return 32'($urandom_range(0, 262143)) - 32'd131072;
         default:    return $urandom;
      endcase
   endfunction

   // ln of a uniform sample is never positive
   function automatic logic signed [31:0] rand_log();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return '0;
         2, 3, 4: return -32'($urandom_range(0, 262143));
         default: return {1'b1, 31'($urandom)};
      endcase
   endfunction

   function automatic spin_request_type noise_request();
      spin_request_type r;
      r.kind      = REQ_IGNORED;
      r.slice_idx = 3'($urandom);
      r.spin      = 10'($urandom);
      r.partner   = 10'($urandom);
      r.coupling  = $urandom;
      r.up_value  = 1'($urandom);
      r.field     = $urandom;
      r.ln_draw   = rand_log();
      r.last      = 1'($urandom);
      return r;
   endfunction

   task automatic drive_request(input spin_request_type r);
      int gap;
      gap = idle_span();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= r.kind;
      req_ch.trotter       <= r.slice_idx;
      req_ch.spin_index    <= r.spin;
      req_ch.partner_index <= r.partner;
      req_ch.coupling      <= r.coupling;
      req_ch.write_spin    <= r.up_value;
      req_ch.field_h       <= r.field;
      req_ch.log_random    <= r.ln_draw;
      req_ch.last_term     <= r.last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic issue(input spin_request_type r);
      if (r.kind == REQ_WRITE && !spin_loaded[r.slice_idx][r.spin]) begin
         spin_loaded[r.slice_idx][r.spin] = 1'b1;
         loaded_addrs.push_back(int'(r.slice_idx) * SPIN_TOTAL + int'(r.spin));
      end
      if (r.kind != REQ_IGNORED) items_sent++;
      drive_request(r);
   endtask

   task automatic write_spin(input int m, input int i, input bit v);
      spin_request_type r;
      r = noise_request();
      r.kind      = REQ_WRITE;
      r.slice_idx = 3'(m);
      r.spin      = 10'(i);
      r.up_value  = v;
      issue(r);
   endtask

   task automatic read_any();
      spin_request_type r;
      int               addr;
      addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
      r = noise_request();
      r.kind      = REQ_READ;
      r.slice_idx = 3'(addr / SPIN_TOTAL);
      r.spin      = 10'(addr % SPIN_TOTAL);
      issue(r);
   endtask

   task automatic send_coupling(input int m, input int i, input int j,
                                input logic signed [31:0] cpl, input logic signed [31:0] h,
                                input logic signed [31:0] lr, input bit last);
      spin_request_type r;
      r = noise_request();
      r.kind      = REQ_COUPLING;
      r.slice_idx = 3'(m);
      r.spin      = 10'(i);
      r.partner   = 10'(j);
      r.coupling  = cpl;
      r.field     = h;
      r.ln_draw   = lr;
      r.last      = last;
      issue(r);
   endtask

   task automatic ignored_item();
      spin_request_type r;
      r = noise_request();
      issue(r);
   endtask

   // every slice of the target column is loaded so any ring neighbor is known
   task automatic coupling_run(input int m, input int i, input int terms);
      int j;
      for (int s = 0; s < 8; s++) begin
         if (!spin_loaded[s][i]) write_spin(s, i, 1'($urandom));
      end
      for (int k = 0; k < terms; k++) begin
         if ($urandom_range(0, 1))
            j = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)] % SPIN_TOTAL;
         else
            j = $urandom_range(0, SPIN_TOTAL - 1);
         if (!spin_loaded[m][j]) write_spin(m, j, 1'($urandom));
         if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
               0:       read_any();
               1:       ignored_item();
               default: write_spin($urandom_range(0, 7), $urandom_range(0, SPIN_TOTAL - 1),
                                   1'($urandom));
            endcase
         end
         send_coupling(m, i, j, rand_q16(), rand_q16(), rand_log(), k == terms - 1);
      end
   endtask

   task automatic random_traffic(input int count);
      int stop_at;
      int roll;
      int i;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            if ($urandom_range(0, 1))
               i = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)] % SPIN_TOTAL;
            else
               i = $urandom_range(0, SPIN_TOTAL - 1);
            coupling_run($urandom_range(0, 7), i,
                         ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6)
                                                     : $urandom_range(7, 40));
         end else if (roll < 86) begin
            read_any();
         end else if (roll < 95) begin
            write_spin($urandom_range(0, 7), $urandom_range(0, SPIN_TOTAL - 1), 1'($urandom));
         end else begin
            ignored_item();
         end
      end
   endtask

   task automatic directed_checks();
      spin_request_type r;
      // both ring neighbors up
      write_spin(0, 0, 1'b1);
      write_spin(1, 0, 1'b1);
      write_spin(7, 0, 1'b1);
      read_any();
      send_coupling(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1);
      // top slice wraps its down neighbor to slice 0, both down
      write_spin(7, 1023, 1'b0);
      write_spin(6, 1023, 1'b0);
      write_spin(0, 1023, 1'b0);
      send_coupling(7, 1023, 1023, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
      send_coupling(7, 1023, 1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
      r = noise_request();
      r.kind      = REQ_READ;
      r.slice_idx = 3'd7;
      r.spin      = 10'd1023;
      r.last      = 1'b1;
      issue(r);
      r = '{kind: REQ_IGNORED, slice_idx: '1, spin: '1, partner: '1, coupling: '1,
            up_value: 1'b1, field: '1, ln_draw: '1, last: 1'b1};
      issue(r);
      // neighbors disagree; energy equal to threshold must not flip
      write_spin(1, 0, 1'b0);
      send_coupling(0, 0, 0, 32'h0, 32'h0, 32'h0, 1'b1);
      r = noise_request();
      r.kind      = REQ_READ;
      r.slice_idx = 3'd0;
      r.spin      = 10'd0;
      issue(r);
      // threshold one below the energy flips
      send_coupling(0, 0, 0, 32'h0, 32'h0, 32'hffff_ffff, 1'b1);
   endtask

   function automatic void phase_settings(input int phase, output logic [3:0] count,
                                          output logic [31:0] qe, output logic [31:0] hib);
      case (phase)
         1: begin count = 4'd8;  qe = 32'h0003_0000; hib = 32'h0000_8000; end
         2: begin count = 4'd0;  qe = 32'h8000_0000; hib = 32'h0;         end
         3: begin count = 4'd15; qe = 32'h7fff_ffff; hib = 32'h7fff_ffff; end
         4: begin count = 4'd1;  qe = $urandom;      hib = $urandom_range(0, 32'h3ffff); end
         5: begin count = 4'd3;  qe = 32'hffff_0000; hib = 32'h0001_0000; end
         6: begin count = 4'd9;  qe = $urandom;      hib = $urandom;      end
         default: begin
            count = 4'd5;
            qe    = 32'($urandom_range(0, 262143)) - 32'd131072;
            hib   = 32'h0000_0100;
         end
      endcase
   endfunction

   task automatic settle();
      while (pending_results != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // response side: random stalls, one long hold-off while items keep coming
   initial begin : rsp_stall
      int span;
      rsp_ch.ready <= 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (squeeze_pending) begin
            rsp_ch.ready    <= 1'b0;
            span            = 160;
            squeeze_pending = 1'b0;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin rsp_ch.ready <= 1'b1; span = $urandom_range(1, 12);   end
               6, 7:             begin rsp_ch.ready <= 1'b0; span = $urandom_range(1, 3);    end
               8:                begin rsp_ch.ready <= 1'b0; span = $urandom_range(8, 40);   end
               default:          begin rsp_ch.ready <= 1'b1; span = $urandom_range(60, 150); end
            endcase
         end
         repeat (span) @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [3:0]  count;
      logic [31:0] qe;
      logic [31:0] hib;
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= REQ_WRITE;
      req_ch.trotter       <= '0;
      req_ch.spin_index    <= '0;
      req_ch.partner_index <= '0;
      req_ch.coupling      <= '0;
      req_ch.write_spin    <= 1'b0;
      req_ch.field_h       <= '0;
      req_ch.log_random    <= '0;
      req_ch.last_term     <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= CSR_TROTTER_COUNT;
      csr_ch.data          <= '0;
      sender_gaps = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_checks();
      req_ch.valid <= 1'b0;
      for (int phase = 1; phase <= 7; phase++) begin
         settle();
         phase_settings(phase, count, qe, hib);
         write_register(CSR_TROTTER_COUNT, {28'($urandom), count});
         write_register(CSR_QUANTUM_ENERGY, qe);
         write_register(CSR_HALF_INV_BETA, {1'($urandom), hib[30:0]});
         csr_ch.valid <= 1'b0;
         sender_gaps = (phase % 3) != 0;
         if (phase == 1) squeeze_pending = 1'b1;
         random_traffic(PHASE_ITEMS);
         req_ch.valid <= 1'b0;
      end
      settle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** sqa_trotter_spin_update: PASSED **");
      end else begin
         $display("** sqa_trotter_spin_update: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #12_000_000;
      $display("** sqa_trotter_spin_update: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sqa_trotter_spin_update.f -----
+incdir+hdl
hdl/sqa_tsu_pkg.sv
hdl/sqa_tsu_if.sv
hdl/sqa_tsu_csr.sv
hdl/sqa_tsu_spin_bank.sv
hdl/sqa_tsu_update.sv
hdl/sqa_trotter_spin_update.sv
hdl/sqa_tsu_check.sv
verif/sqa_tsu_flip_checker.sv
verif/tb_sqa_trotter_spin_update.sv
